@@ rtl/brfp_pkg.sv @@
package brfp_pkg;

  // Field codes carried on field_code_o. Length fields and their text fields
  // come in pairs for the five record strings and the two property strings.
  typedef enum logic [4:0] {
    FLD_DOMAIN_LEN = 5'd0,
    FLD_DOMAIN_TXT = 5'd1,
    FLD_PATH_LEN   = 5'd2,
    FLD_PATH_TXT   = 5'd3,
    FLD_TARGET_LEN = 5'd4,
    FLD_TARGET_TXT = 5'd5,
    FLD_HASH_LEN   = 5'd6,
    FLD_HASH_TXT   = 5'd7,
    FLD_EXTRA_LEN  = 5'd8,
    FLD_EXTRA_TXT  = 5'd9,
    FLD_MODE       = 5'd10,
    FLD_WORD0      = 5'd11,
    FLD_WORD1      = 5'd12,
    FLD_WORD2      = 5'd13,
    FLD_WORD3      = 5'd14,
    FLD_WORD4      = 5'd15,
    FLD_WORD5      = 5'd16,
    FLD_WORD6      = 5'd17,
    FLD_SIZE       = 5'd18,
    FLD_FLAG       = 5'd19,
    FLD_PROP_COUNT = 5'd20,
    FLD_PNAME_LEN  = 5'd21,
    FLD_PNAME_TXT  = 5'd22,
    FLD_PVAL_LEN   = 5'd23,
    FLD_PVAL_TXT   = 5'd24
  } field_e;

  // A record string length with this value means the string is absent.
  localparam logic [15:0] EMPTY_MARK = 16'hFFFF;

  localparam int unsigned RecSizeW = 26;

  // True for fields whose bytes are string text rather than a number.
  function automatic logic field_is_text(field_e code);
    logic txt;
    txt = 1'b0;
    if (code <= FLD_EXTRA_TXT) begin
      txt = code[0];
    end else if (code == FLD_PNAME_TXT || code == FLD_PVAL_TXT) begin
      txt = 1'b1;
    end
    return txt;
  endfunction

  // Byte width of a numeric or length field.
  function automatic logic [3:0] field_width(field_e code);
    logic [3:0] w;
    if (code <= FLD_MODE || code == FLD_PNAME_LEN || code == FLD_PVAL_LEN) begin
      w = 4'd2;
    end else if (code <= FLD_WORD6) begin
      w = 4'd4;
    end else if (code == FLD_SIZE) begin
      w = 4'd8;
    end else begin
      w = 4'd1;
    end
    return w;
  endfunction

endpackage

@@ rtl/backup_record_field_parser.sv @@
// Each accepted byte is registered into the output register at the clock edge that
// takes it. Throughput: one byte per cycle while in_stall_o is low, set by the single
// field state register that every byte reads and updates.
// Reset (rst_ni low, asynchronous) returns the parser to the domain length field of a
// fresh record with all counters cleared and the output register empty.
module backup_record_field_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,

  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [7:0]                    data_byte_i,

  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [4:0]                    field_code_o,
  output logic [7:0]                    property_index_o,
  output logic [15:0]                   byte_index_o,
  output logic [7:0]                    byte_value_o,
  output logic                          field_done_o,
  output logic [63:0]                   field_value_o,
  output logic                          record_done_o,
  output logic [brfp_pkg::RecSizeW-1:0] record_size_o
);

  // Parser state. Each byte reads it and writes its successor in the same cycle,
  // so the whole field walk is one pass of logic between input and result.
  brfp_pkg::field_e                cur_q, cur_d;
  logic [15:0]                     pos_q, pos_d;
  logic [15:0]                     pend_q, pend_d;
  logic [63:0]                     acc_q, acc_d;
  logic [7:0]                      props_exp_q, props_exp_d;
  logic [7:0]                      prop_cnt_q, prop_cnt_d;
  logic [brfp_pkg::RecSizeW-1:0]   bytes_q, bytes_d;

  // Output register. It takes a new result whenever it is empty or its current
  // result is being transferred out, so the input side is stalled only while a
  // result sits waiting on a stalled consumer.
  logic                            out_valid_q;
  logic [4:0]                      field_code_q;
  logic [7:0]                      property_index_q;
  logic [15:0]                     byte_index_q;
  logic [7:0]                      byte_value_q;
  logic                            field_done_q;
  logic [63:0]                     field_value_q;
  logic                            record_done_q;
  logic [brfp_pkg::RecSizeW-1:0]   record_size_q;

  logic                            in_accept;

  // Per-byte decode.
  brfp_pkg::field_e                code;
  brfp_pkg::field_e                next;
  logic                            is_text;
  logic [16:0]                     pos_inc;
  logic [63:0]                     acc;
  logic                            done;
  logic [63:0]                     value;
  logic [15:0]                     len;
  logic                            prop_end;
  logic                            rec_end;
  logic [8:0]                      cnt_inc;
  logic [brfp_pkg::RecSizeW-1:0]   rec_size;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  always_comb begin
    // A code past the last property field cannot be reached; it decodes as the
    // domain length so the parser would recover at a record boundary.
    if (cur_q > brfp_pkg::FLD_PVAL_TXT) begin
      code = brfp_pkg::FLD_DOMAIN_LEN;
    end else begin
      code = cur_q;
    end

    is_text  = brfp_pkg::field_is_text(code);
    pos_inc  = {1'b0, pos_q} + 17'd1;
    // Numeric fields shift in big-endian; the first byte starts from zero.
    acc      = (pos_q == 16'd0) ? {56'd0, data_byte_i} : {acc_q[55:0], data_byte_i};

    if (is_text) begin
      done = (pos_inc >= {1'b0, pend_q});
    end else begin
      done = (pos_inc >= {13'd0, brfp_pkg::field_width(code)});
    end

    value    = (!is_text && done) ? acc : 64'd0;
    len      = value[15:0];
    cnt_inc  = {1'b0, prop_cnt_q} + 9'd1;
    rec_size = bytes_q + {{(brfp_pkg::RecSizeW-1){1'b0}}, 1'b1};

    cur_d       = cur_q;
    pos_d       = pos_q;
    pend_d      = pend_q;
    acc_d       = acc_q;
    props_exp_d = props_exp_q;
    prop_cnt_d  = prop_cnt_q;
    next        = code;
    prop_end    = 1'b0;
    rec_end     = 1'b0;

    if (!is_text) begin
      acc_d = acc;
    end

    if (!done) begin
      pos_d = pos_inc[15:0];
    end else begin
      pos_d = 16'd0;
      acc_d = 64'd0;
      if (code <= brfp_pkg::FLD_EXTRA_TXT && !code[0]) begin
        // Record string length: zero or the empty mark skips the text field.
        if (len == 16'd0 || len == brfp_pkg::EMPTY_MARK) begin
          next = brfp_pkg::field_e'(code + 5'd2);
        end else begin
          pend_d = len;
          next   = brfp_pkg::field_e'(code + 5'd1);
        end
      end else if (code < brfp_pkg::FLD_PROP_COUNT) begin
        next = brfp_pkg::field_e'(code + 5'd1);
      end else if (code == brfp_pkg::FLD_PROP_COUNT) begin
        props_exp_d = data_byte_i;
        prop_cnt_d  = 8'd0;
        if (data_byte_i == 8'd0) begin
          rec_end = 1'b1;
        end else begin
          next = brfp_pkg::FLD_PNAME_LEN;
        end
      end else if (code == brfp_pkg::FLD_PNAME_LEN) begin
        // Property lengths are literal; only zero skips the text.
        if (len == 16'd0) begin
          next = brfp_pkg::FLD_PVAL_LEN;
        end else begin
          pend_d = len;
          next   = brfp_pkg::FLD_PNAME_TXT;
        end
      end else if (code == brfp_pkg::FLD_PNAME_TXT) begin
        next = brfp_pkg::FLD_PVAL_LEN;
      end else if (code == brfp_pkg::FLD_PVAL_LEN) begin
        if (len == 16'd0) begin
          prop_end = 1'b1;
        end else begin
          pend_d = len;
          next   = brfp_pkg::FLD_PVAL_TXT;
        end
      end else begin
        prop_end = 1'b1;
      end

      if (prop_end) begin
        if (cnt_inc >= {1'b0, props_exp_q}) begin
          rec_end = 1'b1;
        end else begin
          prop_cnt_d = cnt_inc[7:0];
          next       = brfp_pkg::FLD_PNAME_LEN;
        end
      end
      cur_d = next;
    end

    // The last byte of a record puts every field of the state back to its
    // reset value, so the next byte starts a new record.
    if (rec_end) begin
      cur_d       = brfp_pkg::FLD_DOMAIN_LEN;
      pos_d       = 16'd0;
      pend_d      = 16'd0;
      acc_d       = 64'd0;
      props_exp_d = 8'd0;
      prop_cnt_d  = 8'd0;
      bytes_d     = '0;
    end else begin
      bytes_d     = rec_size;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= brfp_pkg::FLD_DOMAIN_LEN;
      pos_q       <= 16'd0;
      pend_q      <= 16'd0;
      acc_q       <= 64'd0;
      props_exp_q <= 8'd0;
      prop_cnt_q  <= 8'd0;
      bytes_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= in_accept | in_stall_o;
      if (in_accept) begin
        cur_q       <= cur_d;
        pos_q       <= pos_d;
        pend_q      <= pend_d;
        acc_q       <= acc_d;
        props_exp_q <= props_exp_d;
        prop_cnt_q  <= prop_cnt_d;
        bytes_q     <= bytes_d;
      end
    end
  end

  // Result payload; it holds whenever no new byte is accepted.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      field_code_q     <= code;
      property_index_q <= (code >= brfp_pkg::FLD_PNAME_LEN) ? prop_cnt_q : 8'd0;
      byte_index_q     <= pos_q;
      byte_value_q     <= data_byte_i;
      field_done_q     <= done;
      field_value_q    <= value;
      record_done_q    <= rec_end;
      record_size_q    <= rec_end ? rec_size : '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign field_code_o     = field_code_q;
  assign property_index_o = property_index_q;
  assign byte_index_o     = byte_index_q;
  assign byte_value_o     = byte_value_q;
  assign field_done_o     = field_done_q;
  assign field_value_o    = field_value_q;
  assign record_done_o    = record_done_q;
  assign record_size_o    = record_size_q;

endmodule
